[src/time_gated_cell_energy_binner_macros.svh]
// Assertion macros used by the binner RTL.
`ifndef TIME_GATED_CELL_ENERGY_BINNER_MACROS_SVH
`define TIME_GATED_CELL_ENERGY_BINNER_MACROS_SVH

`ifndef SYNTHESIS

`define TGCEB_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("binner assertion failed");

`define TGCEB_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("binner forbidden condition seen");

`else

`define TGCEB_ASSERT(label, prop)

`define TGCEB_NEVER(label, cond)

`endif

`endif

[src/tgceb_pkg.sv]
package tgceb_pkg;

	localparam int ROWS = 320;
	localparam int COLUMNS = 27;
	localparam int FIXED_COLUMNS = 24;
	localparam int CELLS = ROWS * COLUMNS;

	localparam int TIME_W = 16;
	localparam int ROW_W = 9;
	localparam int COL_W = 5;
	localparam int ENERGY_W = 24;
	localparam int SUM_W = 32;
	localparam int DATA_W = 4 * SUM_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = 24;

	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ROWC_W = $clog2(ROWS + 1);
	localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int GRP_BITS = 5;
	localparam int GRP_SIZE = 1 << GRP_BITS;
	localparam int NGRP = (ROWS + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_AW = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int FCOL_W = (FIXED_COLUMNS > 1) ? $clog2(FIXED_COLUMNS) : 1;

	localparam logic [COLUMNS-1:0] COL_ONE = COLUMNS'(1);
	localparam logic [GRP_SIZE-1:0] GRP_ONE = GRP_SIZE'(1);
	localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
	localparam logic [FCOL_W-1:0] FCOL_LAST = FCOL_W'(FIXED_COLUMNS - 1);

	localparam logic signed [TIME_W-1:0] TIME_MIN_RST = -16'sd320;
	localparam logic signed [TIME_W-1:0] TIME_MAX_RST = 16'sd960;
	localparam logic [15:0] MAX_DURATION_RST = 16'd1600;
	localparam logic [ROW_W-1:0] FIXED_ROW_COUNT_RST = 9'd320;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_ENERGY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_ROW_COUNT = 3'd5;

	typedef enum logic [2:0] {
		ST_ADDED = 3'd0,
		ST_TIME = 3'd1,
		ST_RANGE = 3'd2,
		ST_CELL = 3'd3,
		ST_NONE = 3'd4,
		ST_IGNORED = 3'd5
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CLEAR = 7'b0000010,
		S_HIT = 7'b0000100,
		S_RSUM = 7'b0001000,
		S_ROCC = 7'b0010000,
		S_RDAT = 7'b0100000,
		S_SIMPLE = 7'b1000000
	} state_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [ENERGY_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W + 1)'(b);
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

	function automatic logic [CELL_AW-1:0] cell_index(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return CELL_AW'(int'(r) * COLUMNS + int'(c));
	endfunction

	function automatic logic [GRP_AW-1:0] grp_of(input logic [ROW_W-1:0] r);
		return GRP_AW'(r >> GRP_BITS);
	endfunction

	function automatic logic [ROW_W-1:0] row_of(input logic [GRP_AW-1:0] g,
			input logic [GRP_BITS-1:0] lo);
		return ROW_W'(int'(g) * GRP_SIZE + int'(lo));
	endfunction

	function automatic logic [ROW_W-1:0] fixed_row_out(input logic [ROW_AW-1:0] r);
		return ROW_W'(r);
	endfunction

	function automatic logic [COL_W-1:0] fixed_col_out(input logic [FCOL_W-1:0] c);
		return COL_W'(c);
	endfunction

	function automatic logic [ROWC_W-1:0] clamp_rows(input logic [ROW_W-1:0] n);
		logic [ROWC_W-1:0] r;
		if (n == '0) begin
			r = ROWC_W'(1);
		end else if (int'(n) > ROWS) begin
			r = ROWC_W'(ROWS);
		end else begin
			r = ROWC_W'(n);
		end
		return r;
	endfunction

	function automatic logic [GRP_AW-1:0] first_grp(input logic [NGRP-1:0] v);
		logic [GRP_AW-1:0] r;
		r = '0;
		for (int i = NGRP - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = GRP_AW'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [GRP_BITS-1:0] first_row(input logic [GRP_SIZE-1:0] v);
		logic [GRP_BITS-1:0] r;
		r = '0;
		for (int i = GRP_SIZE - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = GRP_BITS'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [COL_W-1:0] first_col(input logic [COLUMNS-1:0] v);
		logic [COL_W-1:0] r;
		r = '0;
		for (int i = COLUMNS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = COL_W'(i);
			end
		end
		return r;
	endfunction

endpackage

[src/time_gated_cell_energy_binner.sv]
// Time-gated cell energy binner.
// Input words arrive on in_valid/in_ready. A hit word (func 0) is gated by the
// time window and duration limit and then summed into its cell; a read word
// (func 1) returns the first occupied cell in row-major order and clears it.
// Each input word gives exactly one result word on out_valid/out_ready.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and take effect on the next word.
// A hit first reads its cell and then does the saturating add and write-back
// of the cell. A read walks the occupancy bitmap search level by level (group
// summary, row summary, row word) and then reads the cell data.
// Rejected hits, empty reads and all fixed-mode words go straight to their result.
// One word is in flight at a time; the next word is accepted once the
// previous result sits in the output register, even if it is not taken yet.
// A stalled receiver holds the last stage until the output register frees.
// After reset the occupancy bitmap is cleared one row per cycle; in_ready stays
// low during that pass, configuration writes are taken as usual.

`include "time_gated_cell_energy_binner_macros.svh"

module time_gated_cell_energy_binner (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	input logic signed [15:0] t_start,
	input logic signed [15:0] t_end,
	input logic [8:0] row,
	input logic [4:0] column,
	input logic [23:0] edep,
	input logic [23:0] eion,
	input logic [23:0] light,
	input logic [23:0] raw_light,
	input logic raw_light_valid,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] status,
	output logic [8:0] cell_row,
	output logic [4:0] cell_column,
	output logic [31:0] edep_sum,
	output logic [31:0] eion_sum,
	output logic [31:0] light_sum,
	output logic [31:0] raw_light_sum,
	output logic last,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data
);

	tgceb_pkg::state_t state_q;
	logic [tgceb_pkg::ROW_AW-1:0] clr_cnt_q;
	logic [tgceb_pkg::NGRP-1:0] grp_nz_q;
	logic [tgceb_pkg::GRP_AW-1:0] g_q;
	logic [tgceb_pkg::GRP_SIZE-1:0] rs_word_q;
	tgceb_pkg::status_t pend_q;
	logic [tgceb_pkg::ROW_W-1:0] row_q;
	logic [tgceb_pkg::COL_W-1:0] col_q;
	logic [tgceb_pkg::ENERGY_W-1:0] edep_q;
	logic [tgceb_pkg::ENERGY_W-1:0] eion_q;
	logic [tgceb_pkg::ENERGY_W-1:0] light_q;
	logic [tgceb_pkg::ENERGY_W-1:0] raw_q;
	logic rawv_q;
	logic [tgceb_pkg::CELL_AW-1:0] idx_q;
	logic [tgceb_pkg::ROW_AW-1:0] fix_row_q;
	logic [tgceb_pkg::FCOL_W-1:0] fix_col_q;

	logic signed [15:0] time_min_q;
	logic signed [15:0] time_max_q;
	logic [15:0] max_duration_q;
	logic fixed_mode_q;
	logic [23:0] fixed_energy_q;
	logic [8:0] fixed_row_count_q;

	logic out_valid_q;
	tgceb_pkg::status_t status_q;
	logic [8:0] cell_row_q;
	logic [4:0] cell_column_q;
	logic [31:0] edep_sum_q;
	logic [31:0] eion_sum_q;
	logic [31:0] light_sum_q;
	logic [31:0] raw_light_sum_q;
	logic last_q;

	logic occ_re;
	logic occ_we;
	logic [tgceb_pkg::ROW_AW-1:0] occ_raddr;
	logic [tgceb_pkg::ROW_AW-1:0] occ_waddr;
	logic [tgceb_pkg::COLUMNS-1:0] occ_wdata;
	logic [tgceb_pkg::COLUMNS-1:0] occ_rdata;
	logic rs_re;
	logic rs_we;
	logic [tgceb_pkg::GRP_AW-1:0] rs_raddr;
	logic [tgceb_pkg::GRP_AW-1:0] rs_waddr;
	logic [tgceb_pkg::GRP_SIZE-1:0] rs_wdata;
	logic [tgceb_pkg::GRP_SIZE-1:0] rs_rdata;
	logic dat_re;
	logic dat_we;
	logic [tgceb_pkg::CELL_AW-1:0] dat_raddr;
	logic [tgceb_pkg::CELL_AW-1:0] dat_waddr;
	logic [tgceb_pkg::DATA_W-1:0] dat_wdata;
	logic [tgceb_pkg::DATA_W-1:0] dat_rdata;

	logic in_fire;
	logic out_free;
	logic signed [16:0] dur;
	logic time_bad;
	logic range_bad;
	logic hit_ok;
	logic [tgceb_pkg::GRP_AW-1:0] in_grp;
	logic [tgceb_pkg::CELL_AW-1:0] in_idx;
	logic [tgceb_pkg::GRP_AW-1:0] nz_first;

	logic [tgceb_pkg::COLUMNS-1:0] hit_col_bit;
	logic [tgceb_pkg::GRP_SIZE-1:0] row_bit;
	logic hit_occ;
	logic [tgceb_pkg::GRP_AW-1:0] hit_grp;
	logic [tgceb_pkg::SUM_W-1:0] base_edep;
	logic [tgceb_pkg::SUM_W-1:0] base_eion;
	logic [tgceb_pkg::SUM_W-1:0] base_light;
	logic [tgceb_pkg::SUM_W-1:0] base_raw;
	logic [tgceb_pkg::SUM_W-1:0] new_raw;

	logic [tgceb_pkg::ROW_W-1:0] sel_row;
	logic [tgceb_pkg::COL_W-1:0] occ_first;
	logic [tgceb_pkg::COLUMNS-1:0] occ_left;
	logic [tgceb_pkg::GRP_SIZE-1:0] rs_left;
	logic [tgceb_pkg::CELL_AW-1:0] rd_idx;

	logic [tgceb_pkg::ROWC_W-1:0] rows_eff;
	logic wrap;
	logic [tgceb_pkg::ROW_AW-1:0] cur_row;
	logic [tgceb_pkg::FCOL_W-1:0] cur_col;
	logic fix_last;

	tgceb_ram #(
		.WIDTH(tgceb_pkg::COLUMNS),
		.DEPTH(tgceb_pkg::ROWS)
	) u_occ_ram (
		.clk(clk),
		.we(occ_we),
		.waddr(occ_waddr),
		.wdata(occ_wdata),
		.re(occ_re),
		.raddr(occ_raddr),
		.rdata(occ_rdata)
	);

	tgceb_ram #(
		.WIDTH(tgceb_pkg::GRP_SIZE),
		.DEPTH(tgceb_pkg::NGRP)
	) u_rsum_ram (
		.clk(clk),
		.we(rs_we),
		.waddr(rs_waddr),
		.wdata(rs_wdata),
		.re(rs_re),
		.raddr(rs_raddr),
		.rdata(rs_rdata)
	);

	tgceb_ram #(
		.WIDTH(tgceb_pkg::DATA_W),
		.DEPTH(tgceb_pkg::CELLS)
	) u_data_ram (
		.clk(clk),
		.we(dat_we),
		.waddr(dat_waddr),
		.wdata(dat_wdata),
		.re(dat_re),
		.raddr(dat_raddr),
		.rdata(dat_rdata)
	);

	assign in_ready = (state_q == tgceb_pkg::S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign dur = {t_end[15], t_end} - {t_start[15], t_start};
	assign time_bad = (t_start > time_max_q) || (t_end < time_min_q)
		|| (dur > $signed({1'b0, max_duration_q}));
	assign range_bad = (int'(row) >= tgceb_pkg::ROWS) || (int'(column) >= tgceb_pkg::COLUMNS);
	assign hit_ok = !fixed_mode_q && !func && !time_bad && !range_bad;
	assign in_grp = tgceb_pkg::grp_of(row);
	assign in_idx = tgceb_pkg::cell_index(row, column);
	assign nz_first = tgceb_pkg::first_grp(grp_nz_q);

	assign hit_col_bit = tgceb_pkg::COL_ONE << col_q;
	assign row_bit = tgceb_pkg::GRP_ONE << row_q[tgceb_pkg::GRP_BITS-1:0];
	assign hit_occ = |(occ_rdata & hit_col_bit);
	assign hit_grp = tgceb_pkg::grp_of(row_q);
	assign base_edep = hit_occ ? dat_rdata[tgceb_pkg::SUM_W-1:0] : '0;
	assign base_eion = hit_occ ? dat_rdata[2*tgceb_pkg::SUM_W-1:tgceb_pkg::SUM_W] : '0;
	assign base_light = hit_occ ? dat_rdata[3*tgceb_pkg::SUM_W-1:2*tgceb_pkg::SUM_W] : '0;
	assign base_raw = hit_occ ? dat_rdata[4*tgceb_pkg::SUM_W-1:3*tgceb_pkg::SUM_W] : '0;
	assign new_raw = rawv_q ? tgceb_pkg::sat_add(base_raw, raw_q) : base_raw;

	assign sel_row = tgceb_pkg::row_of(g_q, tgceb_pkg::first_row(rs_rdata));
	assign occ_first = tgceb_pkg::first_col(occ_rdata);
	assign occ_left = occ_rdata & ~(tgceb_pkg::COL_ONE << occ_first);
	assign rs_left = rs_word_q & ~row_bit;
	assign rd_idx = tgceb_pkg::cell_index(row_q, occ_first);

	assign rows_eff = tgceb_pkg::clamp_rows(fixed_row_count_q);
	assign wrap = int'(fix_row_q) >= int'(rows_eff);
	assign cur_row = wrap ? '0 : fix_row_q;
	assign cur_col = wrap ? '0 : fix_col_q;
	assign fix_last = (int'(cur_row) == int'(rows_eff) - 1) && (cur_col == tgceb_pkg::FCOL_LAST);

	always_comb begin
		occ_re = 1'b0;
		occ_we = 1'b0;
		occ_raddr = row[tgceb_pkg::ROW_AW-1:0];
		occ_waddr = row_q[tgceb_pkg::ROW_AW-1:0];
		occ_wdata = '0;
		rs_re = 1'b0;
		rs_we = 1'b0;
		rs_raddr = in_grp;
		rs_waddr = hit_grp;
		rs_wdata = '0;
		dat_re = 1'b0;
		dat_we = 1'b0;
		dat_raddr = in_idx;
		dat_waddr = idx_q;
		dat_wdata = {new_raw,
			tgceb_pkg::sat_add(base_light, light_q),
			tgceb_pkg::sat_add(base_eion, eion_q),
			tgceb_pkg::sat_add(base_edep, edep_q)};
		unique case (state_q)
			tgceb_pkg::S_CLEAR: begin
				occ_we = 1'b1;
				occ_waddr = clr_cnt_q;
				rs_we = int'(clr_cnt_q) < tgceb_pkg::NGRP;
				rs_waddr = clr_cnt_q[tgceb_pkg::GRP_AW-1:0];
			end
			tgceb_pkg::S_IDLE: begin
				if (in_fire && hit_ok) begin
					occ_re = 1'b1;
					rs_re = 1'b1;
					dat_re = 1'b1;
				end else if (in_fire && !fixed_mode_q && func && (grp_nz_q != '0)) begin
					rs_re = 1'b1;
					rs_raddr = nz_first;
				end
			end
			tgceb_pkg::S_HIT: begin
				if (out_free) begin
					dat_we = 1'b1;
					occ_we = 1'b1;
					occ_wdata = occ_rdata | hit_col_bit;
					rs_we = 1'b1;
					rs_wdata = rs_rdata | row_bit;
				end
			end
			tgceb_pkg::S_RSUM: begin
				occ_re = 1'b1;
				occ_raddr = sel_row[tgceb_pkg::ROW_AW-1:0];
			end
			tgceb_pkg::S_ROCC: begin
				dat_re = 1'b1;
				dat_raddr = rd_idx;
				occ_we = 1'b1;
				occ_wdata = occ_left;
				rs_we = (occ_left == '0);
				rs_waddr = g_q;
				rs_wdata = rs_left;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgceb_pkg::S_CLEAR;
			clr_cnt_q <= '0;
			grp_nz_q <= '0;
			fix_row_q <= '0;
			fix_col_q <= '0;
			out_valid_q <= 1'b0;
			time_min_q <= tgceb_pkg::TIME_MIN_RST;
			time_max_q <= tgceb_pkg::TIME_MAX_RST;
			max_duration_q <= tgceb_pkg::MAX_DURATION_RST;
			fixed_mode_q <= 1'b0;
			fixed_energy_q <= '0;
			fixed_row_count_q <= tgceb_pkg::FIXED_ROW_COUNT_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tgceb_pkg::REG_TIME_MIN: time_min_q <= cfg_data[15:0];
					tgceb_pkg::REG_TIME_MAX: time_max_q <= cfg_data[15:0];
					tgceb_pkg::REG_MAX_DURATION: max_duration_q <= cfg_data[15:0];
					tgceb_pkg::REG_FIXED_MODE: fixed_mode_q <= cfg_data[0];
					tgceb_pkg::REG_FIXED_ENERGY: fixed_energy_q <= cfg_data;
					tgceb_pkg::REG_FIXED_ROW_COUNT: fixed_row_count_q <= cfg_data[8:0];
					default: begin
					end
				endcase
			end

			if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				tgceb_pkg::S_CLEAR: begin
					if (clr_cnt_q == tgceb_pkg::ROW_LAST) begin
						state_q <= tgceb_pkg::S_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				tgceb_pkg::S_IDLE: begin
					if (in_fire) begin
						if (hit_ok) begin
							state_q <= tgceb_pkg::S_HIT;
						end else if (!fixed_mode_q && func && (grp_nz_q != '0)) begin
							state_q <= tgceb_pkg::S_RSUM;
						end else begin
							state_q <= tgceb_pkg::S_SIMPLE;
						end
					end
				end
				tgceb_pkg::S_HIT: begin
					if (out_free) begin
						grp_nz_q[hit_grp] <= 1'b1;
						out_valid_q <= 1'b1;
						state_q <= tgceb_pkg::S_IDLE;
					end
				end
				tgceb_pkg::S_RSUM: begin
					state_q <= tgceb_pkg::S_ROCC;
				end
				tgceb_pkg::S_ROCC: begin
					if ((occ_left == '0) && (rs_left == '0)) begin
						grp_nz_q[g_q] <= 1'b0;
					end
					state_q <= tgceb_pkg::S_RDAT;
				end
				tgceb_pkg::S_RDAT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= tgceb_pkg::S_IDLE;
					end
				end
				tgceb_pkg::S_SIMPLE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= tgceb_pkg::S_IDLE;
						if (pend_q == tgceb_pkg::ST_CELL) begin
							if (fix_last) begin
								fix_row_q <= '0;
								fix_col_q <= '0;
							end else if (cur_col == tgceb_pkg::FCOL_LAST) begin
								fix_row_q <= cur_row + 1'b1;
								fix_col_q <= '0;
							end else begin
								fix_row_q <= cur_row;
								fix_col_q <= cur_col + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= tgceb_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_q <= row;
			col_q <= column;
			edep_q <= edep;
			eion_q <= eion;
			light_q <= light;
			raw_q <= raw_light;
			rawv_q <= raw_light_valid;
			idx_q <= in_idx;
			g_q <= nz_first;
			priority if (fixed_mode_q) begin
				pend_q <= func ? tgceb_pkg::ST_CELL : tgceb_pkg::ST_IGNORED;
			end else if (func) begin
				pend_q <= tgceb_pkg::ST_NONE;
			end else if (time_bad) begin
				pend_q <= tgceb_pkg::ST_TIME;
			end else if (range_bad) begin
				pend_q <= tgceb_pkg::ST_RANGE;
			end else begin
				pend_q <= tgceb_pkg::ST_ADDED;
			end
		end

		if (state_q == tgceb_pkg::S_RSUM) begin
			row_q <= sel_row;
			rs_word_q <= rs_rdata;
		end

		if (state_q == tgceb_pkg::S_ROCC) begin
			col_q <= occ_first;
		end

		if ((state_q == tgceb_pkg::S_HIT) && out_free) begin
			status_q <= tgceb_pkg::ST_ADDED;
			cell_row_q <= '0;
			cell_column_q <= '0;
			edep_sum_q <= '0;
			eion_sum_q <= '0;
			light_sum_q <= '0;
			raw_light_sum_q <= '0;
			last_q <= 1'b0;
		end

		if ((state_q == tgceb_pkg::S_RDAT) && out_free) begin
			status_q <= tgceb_pkg::ST_CELL;
			cell_row_q <= row_q;
			cell_column_q <= col_q;
			edep_sum_q <= dat_rdata[tgceb_pkg::SUM_W-1:0];
			eion_sum_q <= dat_rdata[2*tgceb_pkg::SUM_W-1:tgceb_pkg::SUM_W];
			light_sum_q <= dat_rdata[3*tgceb_pkg::SUM_W-1:2*tgceb_pkg::SUM_W];
			raw_light_sum_q <= dat_rdata[4*tgceb_pkg::SUM_W-1:3*tgceb_pkg::SUM_W];
			last_q <= (grp_nz_q == '0);
		end

		if ((state_q == tgceb_pkg::S_SIMPLE) && out_free) begin
			status_q <= pend_q;
			if (pend_q == tgceb_pkg::ST_CELL) begin
				cell_row_q <= tgceb_pkg::fixed_row_out(cur_row);
				cell_column_q <= tgceb_pkg::fixed_col_out(cur_col);
				edep_sum_q <= 32'(fixed_energy_q);
				eion_sum_q <= 32'(fixed_energy_q);
				light_sum_q <= 32'(fixed_energy_q);
				raw_light_sum_q <= 32'(fixed_energy_q);
				last_q <= fix_last;
			end else begin
				cell_row_q <= '0;
				cell_column_q <= '0;
				edep_sum_q <= '0;
				eion_sum_q <= '0;
				light_sum_q <= '0;
				raw_light_sum_q <= '0;
				last_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign cell_row = cell_row_q;
	assign cell_column = cell_column_q;
	assign edep_sum = edep_sum_q;
	assign eion_sum = eion_sum_q;
	assign light_sum = light_sum_q;
	assign raw_light_sum = raw_light_sum_q;
	assign last = last_q;

	// The group summary steers every bitmap search, so the words it points at must hold a set bit.
	`TGCEB_ASSERT(a_rsum_hit, (state_q == tgceb_pkg::S_RSUM) |-> (rs_rdata != '0))
	`TGCEB_ASSERT(a_occ_hit, (state_q == tgceb_pkg::S_ROCC) |-> (occ_rdata != '0))
	`TGCEB_ASSERT(a_hit_marks, ((state_q == tgceb_pkg::S_HIT) && out_free) |=> (grp_nz_q != '0))
	`TGCEB_NEVER(a_col_range, (state_q == tgceb_pkg::S_RDAT) && (int'(col_q) >= tgceb_pkg::COLUMNS))

endmodule

[src/tgceb_ram.sv]
module tgceb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[bench/time_gated_cell_energy_binner_test.sv]
`timescale 1ns / 1ps

module time_gated_cell_energy_binner_test;
	import tgceb_pkg::*;

	localparam logic FUNC_HIT = 1'b0;
	localparam logic FUNC_READ = 1'b1;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic func;
		logic signed [15:0] t_start;
		logic signed [15:0] t_end;
		logic [8:0] row;
		logic [4:0] column;
		logic [23:0] edep;
		logic [23:0] eion;
		logic [23:0] light;
		logic [23:0] raw_light;
		logic raw_light_valid;
	} hit_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [8:0] cell_row;
		logic [4:0] cell_column;
		logic [31:0] edep_sum;
		logic [31:0] eion_sum;
		logic [31:0] light_sum;
		logic [31:0] raw_light_sum;
		logic last;
	} cell_result_t;

	typedef struct packed {
		logic [31:0] edep;
		logic [31:0] eion;
		logic [31:0] light;
		logic [31:0] raw;
	} cell_sums_t;

	class cell_scoreboard;
		logic signed [15:0] win_lo = TIME_MIN_RST;
		logic signed [15:0] win_hi = TIME_MAX_RST;
		logic [15:0] dur_limit = MAX_DURATION_RST;
		bit fixed_on = 1'b0;
		logic [23:0] fixed_value = '0;
		logic [8:0] fixed_rows = FIXED_ROW_COUNT_RST;
		bit held [CELLS];
		cell_sums_t sums [CELLS];
		int cells_held = 0;
		int walk_pos = 0;
		cell_result_t awaited [$];
		int errors = 0;

		function void set_reg(logic [2:0] idx, logic [23:0] data);
			case (idx)
				REG_TIME_MIN: win_lo = data[15:0];
				REG_TIME_MAX: win_hi = data[15:0];
				REG_MAX_DURATION: dur_limit = data[15:0];
				REG_FIXED_MODE: fixed_on = data[0];
				REG_FIXED_ENERGY: fixed_value = data;
				REG_FIXED_ROW_COUNT: fixed_rows = data[8:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] add_clip(logic [31:0] acc, logic [23:0] amount);
			longint total;
			total = longint'(acc) + longint'(amount);
			return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_word(hit_word_t w);
			cell_result_t r;
			int ts, te, span, pos, total;
			r = '0;
			ts = $signed(w.t_start);
			te = $signed(w.t_end);
			if (w.func == FUNC_HIT) begin
				if (fixed_on) begin
					r.status = ST_IGNORED;
				end else if (ts > int'(win_hi) || te < int'(win_lo)
						|| te - ts > int'(dur_limit)) begin
					r.status = ST_TIME;
				end else if (w.row >= ROWS || w.column >= COLUMNS) begin
					r.status = ST_RANGE;
				end else begin
					pos = int'(w.row) * COLUMNS + int'(w.column);
					if (!held[pos]) begin
						held[pos] = 1'b1;
						sums[pos] = '0;
						cells_held++;
					end
					sums[pos].edep = add_clip(sums[pos].edep, w.edep);
					sums[pos].eion = add_clip(sums[pos].eion, w.eion);
					sums[pos].light = add_clip(sums[pos].light, w.light);
					if (w.raw_light_valid) begin
						sums[pos].raw = add_clip(sums[pos].raw, w.raw_light);
					end
					r.status = ST_ADDED;
				end
			end else if (fixed_on) begin
				span = int'(fixed_rows);
				if (span < 1) begin
					span = 1;
				end else if (span > ROWS) begin
					span = ROWS;
				end
				total = span * FIXED_COLUMNS;
				if (walk_pos >= total) begin
					walk_pos = 0;
				end
				r.status = ST_CELL;
				r.cell_row = 9'(walk_pos / FIXED_COLUMNS);
				r.cell_column = 5'(walk_pos % FIXED_COLUMNS);
				r.edep_sum = fixed_value;
				r.eion_sum = fixed_value;
				r.light_sum = fixed_value;
				r.raw_light_sum = fixed_value;
				if (walk_pos + 1 >= total) begin
					r.last = 1'b1;
					walk_pos = 0;
				end else begin
					walk_pos++;
				end
			end else if (cells_held == 0) begin
				r.status = ST_NONE;
			end else begin
				pos = 0;
				while (!held[pos]) begin
					pos++;
				end
				r.status = ST_CELL;
				r.cell_row = 9'(pos / COLUMNS);
				r.cell_column = 5'(pos % COLUMNS);
				r.edep_sum = sums[pos].edep;
				r.eion_sum = sums[pos].eion;
				r.light_sum = sums[pos].light;
				r.raw_light_sum = sums[pos].raw;
				held[pos] = 1'b0;
				cells_held--;
				r.last = (cells_held == 0);
			end
			awaited.push_back(r);
		endfunction

		function void check_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(cell_result_t got);
			cell_result_t want;
			if (awaited.size() == 0) begin
				$error("result word with status %0d arrived with nothing outstanding",
					got.status);
				errors++;
				return;
			end
			want = awaited.pop_front();
			check_field("status", want.status, got.status);
			check_field("cell_row", want.cell_row, got.cell_row);
			check_field("cell_column", want.cell_column, got.cell_column);
			check_field("edep_sum", want.edep_sum, got.edep_sum);
			check_field("eion_sum", want.eion_sum, got.eion_sum);
			check_field("light_sum", want.light_sum, got.light_sum);
			check_field("raw_light_sum", want.raw_light_sum, got.raw_light_sum);
			check_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic signed [15:0] t_start = '0;
	logic signed [15:0] t_end = '0;
	logic [8:0] row = '0;
	logic [4:0] column = '0;
	logic [23:0] edep = '0;
	logic [23:0] eion = '0;
	logic [23:0] light = '0;
	logic [23:0] raw_light = '0;
	logic raw_light_valid = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [8:0] cell_row;
	logic [4:0] cell_column;
	logic [31:0] edep_sum;
	logic [31:0] eion_sum;
	logic [31:0] light_sum;
	logic [31:0] raw_light_sum;
	logic last;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	bit steady = 1'b0;
	cell_scoreboard sb = new;

	time_gated_cell_energy_binner i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cell_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.cell_row = cell_row;
			got.cell_column = cell_column;
			got.edep_sum = edep_sum;
			got.eion_sum = eion_sum;
			got.light_sum = light_sum;
			got.raw_light_sum = raw_light_sum;
			got.last = last;
			sb.check_result(got);
		end
		out_ready <= steady || ($urandom_range(99) >= 35);
	end

	function automatic logic signed [15:0] to_time(int t);
		if (t > 32767) begin
			t = 32767;
		end else if (t < -32768) begin
			t = -32768;
		end
		return 16'(t);
	endfunction

	function automatic logic [23:0] pick_energy();
		case ($urandom_range(4))
			0, 1: return 24'($urandom);
			2: return 24'hFFFFFF - 24'($urandom_range(0, 255));
			default: return 24'($urandom_range(0, 5000));
		endcase
	endfunction

	function automatic hit_word_t make_hit(int r, int c, int ts, int te, logic [23:0] e,
			bit raw_ok);
		hit_word_t w;
		w.func = FUNC_HIT;
		w.t_start = to_time(ts);
		w.t_end = to_time(te);
		w.row = 9'(r);
		w.column = 5'(c);
		w.edep = e;
		w.eion = e;
		w.light = e;
		w.raw_light = e ^ 24'h000F0F;
		w.raw_light_valid = raw_ok;
		return w;
	endfunction

	function automatic hit_word_t read_word();
		hit_word_t w;
		w = '0;
		w.func = FUNC_READ;
		return w;
	endfunction

	function automatic hit_word_t random_word(int read_pct, int row_hi);
		hit_word_t w;
		int ts, dur;
		w.func = ($urandom_range(99) < read_pct) ? FUNC_READ : FUNC_HIT;
		if ($urandom_range(4) == 0) begin
			w.t_start = 16'($urandom);
			w.t_end = 16'($urandom);
		end else begin
			ts = int'(sb.win_hi) - int'($urandom_range(0, 2000)) + int'($urandom_range(0, 40));
			if ($urandom_range(3) == 0) begin
				dur = int'(sb.dur_limit);
			end else begin
				dur = int'($urandom_range(0, 40 + int'(sb.dur_limit)));
			end
			if ($urandom_range(9) == 0) begin
				dur = -dur;
			end
			w.t_start = to_time(ts);
			w.t_end = to_time(ts + dur);
		end
		case ($urandom_range(24))
			0: begin
				w.row = 9'($urandom_range(ROWS, 511));
				w.column = 5'($urandom);
			end
			1: begin
				w.row = 9'($urandom_range(0, ROWS - 1));
				w.column = 5'($urandom_range(COLUMNS, 31));
			end
			default: begin
				w.row = 9'($urandom_range(0, row_hi));
				w.column = 5'($urandom_range(0, COLUMNS - 1));
			end
		endcase
		w.edep = pick_energy();
		w.eion = pick_energy();
		w.light = pick_energy();
		w.raw_light = pick_energy();
		w.raw_light_valid = $urandom_range(1);
		return w;
	endfunction

	function automatic int idle_run();
		int n;
		n = 0;
		while ($urandom_range(99) < 35) begin
			n++;
		end
		return n;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [23:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(hit_word_t w);
		int gap;
		gap = steady ? 0 : idle_run();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= w.func;
		t_start <= w.t_start;
		t_end <= w.t_end;
		row <= w.row;
		column <= w.column;
		edep <= w.edep;
		eion <= w.eion;
		light <= w.light;
		raw_light <= w.raw_light;
		raw_light_valid <= w.raw_light_valid;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic settle();
		drain();
		repeat (8) @(posedge clk);
	endtask

	task automatic run_random(int count, int read_pct, int row_hi);
		repeat (count) begin
			if ($urandom_range(99) == 0) begin
				drain();
			end
			send_word(random_word(read_pct, row_hi));
		end
	endtask

	task automatic empty_grid();
		while (sb.cells_held > 0) begin
			send_word(read_word());
		end
	endtask

	initial begin
		int r0, c0, ts;
		hit_word_t w;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// The occupancy clear after reset is still running here.
		write_reg(REG_TIME_MIN, 24'hABFEC0);
		write_reg(REG_TIME_MAX, {8'h5C, 16'd960});
		write_reg(REG_MAX_DURATION, 24'd1600);
		write_reg(REG_FIXED_MODE, 24'hFFFFFE);
		write_reg(REG_FIXED_ENERGY, 24'd0);
		write_reg(REG_FIXED_ROW_COUNT, 24'h000140);
		write_reg(REG_SPARE_A, 24'hFFFFFF);
		write_reg(REG_SPARE_B, 24'h123456);

		send_word(read_word());
		send_word(make_hit(0, 0, 0, 100, 24'hFFFFFF, 1'b1));
		send_word(make_hit(ROWS - 1, COLUMNS - 1, 960, 960, 24'h000123, 1'b1));
		send_word(make_hit(1, 1, 961, 970, 24'h000777, 1'b1));
		send_word(make_hit(1, 1, -400, -321, 24'h000777, 1'b1));
		send_word(make_hit(5, 3, -400, -320, 24'h800001, 1'b1));
		send_word(make_hit(2, 2, 0, 1601, 24'h000555, 1'b1));
		send_word(make_hit(2, 2, 0, 1600, 24'hFFFFFF, 1'b0));
		send_word(make_hit(ROWS, 0, 0, 10, 24'h000001, 1'b1));
		send_word(make_hit(511, 31, 0, 10, 24'h000001, 1'b1));
		send_word(make_hit(0, COLUMNS, 0, 10, 24'h000001, 1'b1));
		send_word(make_hit(511, 31, 32767, 32767, 24'h000001, 1'b1));
		send_word(make_hit(0, 0, -32768, 32767, 24'h000001, 1'b1));
		send_word(make_hit(0, 0, 100, 0, 24'hFFFFFF, 1'b1));
		send_word(make_hit(0, 0, 10, 20, 24'h000000, 1'b1));
		repeat (5) send_word(read_word());

		settle();
		write_reg(REG_TIME_MIN, 24'(-int'($urandom_range(0, 800))));
		write_reg(REG_TIME_MAX, 24'($urandom_range(200, 2000)));
		write_reg(REG_MAX_DURATION, 24'($urandom_range(100, 3000)));
		run_random(450, 30, 4);

		steady = 1'b1;
		run_random(300, 25, ROWS - 1);
		steady = 1'b0;

		// Wide open window; one cell takes repeated near-full hits that push its sums toward saturation.
		settle();
		write_reg(REG_TIME_MIN, 24'h008000);
		write_reg(REG_TIME_MAX, 24'h007FFF);
		write_reg(REG_MAX_DURATION, 24'h00FFFF);
		r0 = $urandom_range(0, ROWS - 1);
		c0 = $urandom_range(0, COLUMNS - 1);
		repeat (280) begin
			if ($urandom_range(9) == 0) begin
				w = random_word(20, ROWS - 1);
			end else begin
				ts = int'($urandom_range(0, 1000)) - 500;
				w = make_hit(r0, c0, ts, ts + int'($urandom_range(0, 300)),
					24'hFFFFFF - 24'($urandom_range(0, 4095)), $urandom_range(4) != 0);
			end
			send_word(w);
		end
		empty_grid();

		settle();
		write_reg(REG_TIME_MIN, 24'(-16));
		write_reg(REG_TIME_MAX, 24'd16);
		write_reg(REG_MAX_DURATION, 24'd0);
		run_random(150, 30, 8);

		settle();
		write_reg(REG_TIME_MIN, 24'h7F7FFF);
		write_reg(REG_TIME_MAX, 24'h008000);
		run_random(60, 40, ROWS - 1);

		settle();
		write_reg(REG_FIXED_MODE, 24'h00FF01);
		write_reg(REG_FIXED_ENERGY, 24'hFFFFFF);
		write_reg(REG_FIXED_ROW_COUNT, 24'd1);
		run_random(60, 80, ROWS - 1);
		settle();
		write_reg(REG_FIXED_ROW_COUNT, 24'hFFFE00);
		write_reg(REG_FIXED_ENERGY, 24'd0);
		run_random(40, 80, ROWS - 1);
		settle();
		write_reg(REG_FIXED_ROW_COUNT, 24'd3);
		write_reg(REG_FIXED_ENERGY, 24'($urandom));
		run_random(120, 80, ROWS - 1);
		settle();
		write_reg(REG_FIXED_ROW_COUNT, 24'd320);
		repeat (80) send_word(read_word());
		settle();
		write_reg(REG_FIXED_ROW_COUNT, 24'd2);
		run_random(60, 80, ROWS - 1);
		settle();
		write_reg(REG_FIXED_ROW_COUNT, 24'h0001FF);
		run_random(50, 80, ROWS - 1);
		settle();
		write_reg(REG_FIXED_MODE, 24'h0000FE);

		write_reg(REG_TIME_MIN, 24'(-int'($urandom_range(0, 400))));
		write_reg(REG_TIME_MAX, 24'($urandom_range(500, 1500)));
		write_reg(REG_MAX_DURATION, 24'($urandom_range(800, 2000)));
		run_random(350, 35, 12);
		empty_grid();
		repeat (3) send_word(read_word());

		settle();
		if (sb.errors == 0) begin
			$display("time_gated_cell_energy_binner verification clean");
		end else begin
			$display("time_gated_cell_energy_binner verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("time_gated_cell_energy_binner verification failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/tgceb_pkg.sv
src/tgceb_ram.sv
src/time_gated_cell_energy_binner.sv
bench/time_gated_cell_energy_binner_test.sv
